// ===== hdl/llrs_pkg.sv =====
// llrs_pkg: shared types, constants and helpers for the lost-line recovery sequencer
package llrs_pkg;

    localparam int COUNT_WIDTH = 8;
    localparam int CFG_WIDTH   = 8;
    localparam int CMP_W       = (COUNT_WIDTH > CFG_WIDTH) ? COUNT_WIDTH : CFG_WIDTH;
    localparam int NUM_REGS    = 4;
    localparam int REG_IDX_W   = $clog2(NUM_REGS);

    typedef logic [COUNT_WIDTH-1:0] cnt_t;
    typedef logic [CFG_WIDTH-1:0]   cfg_val_t;
    typedef logic [CMP_W-1:0]       cmp_t;

    typedef enum logic [2:0] {
        ACT_COAST         = 3'd0,
        ACT_MANEUVER      = 3'd1,
        ACT_MANEUVER_STOP = 3'd2,
        ACT_STOP          = 3'd3,
        ACT_RESET_DONE    = 3'd4
    } action_t;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_HOLD_FRAMES     = 2'd0,
        REG_MANEUVER_FRAMES = 2'd1,
        REG_PAUSE_FRAMES    = 2'd2,
        REG_MAX_CYCLES      = 2'd3
    } reg_idx_t;

    localparam cfg_val_t HOLD_RESET     = 8'd5;
    localparam cfg_val_t MANEUVER_RESET = 8'd10;
    localparam cfg_val_t PAUSE_RESET    = 8'd5;
    localparam cfg_val_t MAX_CYC_RESET  = 8'd3;

    localparam logic KIND_LOST  = 1'b0;
    localparam logic KIND_RESET = 1'b1;

    typedef struct packed {
        cfg_val_t hold_frames;
        cfg_val_t maneuver_frames;
        cfg_val_t pause_frames;
        cfg_val_t max_cycles;
    } cfg_t;

    typedef struct packed {
        cnt_t lost_count;
        logic in_pause;
        cnt_t phase_count;
        cnt_t cycle_count;
        logic stopped_for_good;
    } rec_state_t;

    typedef struct packed {
        logic       kind;
        logic [1:0] last_class;
        logic [7:0] confidence;
    } item_t;

    typedef struct packed {
        action_t    action;
        logic [1:0] coast_class;
        logic [7:0] drive_confidence;
        logic       grace_pending;
    } result_t;

    function automatic cnt_t sat_inc(input cnt_t v);
        return (v == '1) ? v : cnt_t'(v + cnt_t'(1));
    endfunction

    function automatic logic ge_cnt_cfg(input cnt_t c, input cfg_val_t lim);
        return cmp_t'(c) >= cmp_t'(lim);
    endfunction

endpackage

// ===== hdl/lost_line_recovery_sequencer_top.sv =====
// lost_line_recovery_sequencer_top: request pipeline, config registers and recovery state
//
// Usage: send one request per camera frame with the line lost (s_kind 0), or a
// recovery reset (s_kind 1). Each request yields exactly one result on the m_
// channel: action code, coast class, drive confidence and grace flag.
// Both channels are valid/ready; a request is taken when s_valid and s_ready are high.
// A request passes an input register, then the step logic into the output
// register. Throughput is one request per cycle while the receiver does not stall;
// the recovery state updates in the same cycle as the step.
// When the receiver stalls, the result holds in the output register and one
// more request can still be taken into the input register; s_ready drops only
// when both are full.
// Configuration: cfg_wr_en writes cfg_wdata to register cfg_index;
// write only while the block is idle.
// Reset (aresetn low, synchronous) empties both stages, clears the recovery
// state and loads the default register values.
module lost_line_recovery_sequencer_top (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [llrs_pkg::REG_IDX_W-1:0]   cfg_index,
    input  logic [llrs_pkg::CFG_WIDTH-1:0]   cfg_wdata,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic                             s_kind,
    input  logic [1:0]                       s_last_class,
    input  logic [7:0]                       s_confidence,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [2:0]                       m_action,
    output logic [1:0]                       m_coast_class,
    output logic [7:0]                       m_drive_confidence,
    output logic                             m_grace_pending
);

    llrs_pkg::cfg_t       cfg_reg;
    llrs_pkg::rec_state_t state_reg;
    llrs_pkg::rec_state_t state_next;
    llrs_pkg::item_t      in_item_reg;
    llrs_pkg::result_t    out_result_reg;
    llrs_pkg::result_t    result_next;
    logic                 in_valid_reg;
    logic                 out_valid_reg;
    logic                 advance;

    assign advance = !out_valid_reg || m_ready;
    assign s_ready = !in_valid_reg || advance;

    llrs_core u_core (
        .cfg        (cfg_reg),
        .state_cur  (state_reg),
        .item       (in_item_reg),
        .state_next (state_next),
        .result     (result_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg            <= 1'b0;
            out_valid_reg           <= 1'b0;
            state_reg               <= '0;
            cfg_reg.hold_frames     <= llrs_pkg::HOLD_RESET;
            cfg_reg.maneuver_frames <= llrs_pkg::MANEUVER_RESET;
            cfg_reg.pause_frames    <= llrs_pkg::PAUSE_RESET;
            cfg_reg.max_cycles      <= llrs_pkg::MAX_CYC_RESET;
        end else begin
            if (cfg_wr_en) begin
                unique case (llrs_pkg::reg_idx_t'(cfg_index))
                    llrs_pkg::REG_HOLD_FRAMES:     cfg_reg.hold_frames     <= cfg_wdata;
                    llrs_pkg::REG_MANEUVER_FRAMES: cfg_reg.maneuver_frames <= cfg_wdata;
                    llrs_pkg::REG_PAUSE_FRAMES:    cfg_reg.pause_frames    <= cfg_wdata;
                    llrs_pkg::REG_MAX_CYCLES:      cfg_reg.max_cycles      <= cfg_wdata;
                    default: ;
                endcase
            end
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= in_valid_reg;
                if (in_valid_reg) begin
                    state_reg <= state_next;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg.kind       <= s_kind;
            in_item_reg.last_class <= s_last_class;
            in_item_reg.confidence <= s_confidence;
        end
        if (advance && in_valid_reg) begin
            out_result_reg <= result_next;
        end
    end

    assign m_valid            = out_valid_reg;
    assign m_action           = out_result_reg.action;
    assign m_coast_class      = out_result_reg.coast_class;
    assign m_drive_confidence = out_result_reg.drive_confidence;
    assign m_grace_pending    = out_result_reg.grace_pending;

endmodule

// ===== hdl/llrs_core.sv =====
// llrs_core: one recovery step, next state and result from the current state and a request
module llrs_core (
    input  llrs_pkg::cfg_t       cfg,
    input  llrs_pkg::rec_state_t state_cur,
    input  llrs_pkg::item_t      item,
    output llrs_pkg::rec_state_t state_next,
    output llrs_pkg::result_t    result
);

    llrs_pkg::cnt_t lost_inc;
    llrs_pkg::cnt_t phase_inc;
    llrs_pkg::cnt_t cycle_inc;

    assign lost_inc  = llrs_pkg::sat_inc(state_cur.lost_count);
    assign phase_inc = llrs_pkg::sat_inc(state_cur.phase_count);
    assign cycle_inc = llrs_pkg::sat_inc(state_cur.cycle_count);

    always_comb begin
        state_next              = state_cur;
        result.action           = llrs_pkg::ACT_COAST;
        result.coast_class      = 2'd0;
        result.drive_confidence = 8'd0;
        result.grace_pending    = 1'b0;
        if (item.kind == llrs_pkg::KIND_RESET) begin
            result.grace_pending = llrs_pkg::ge_cnt_cfg(state_cur.lost_count, cfg.hold_frames);
            result.action        = llrs_pkg::ACT_RESET_DONE;
            state_next           = '0;
        end else if (!llrs_pkg::ge_cnt_cfg(lost_inc, cfg.hold_frames)) begin
            // still coasting
            state_next.lost_count = lost_inc;
            result.action         = llrs_pkg::ACT_COAST;
            result.coast_class    = item.last_class;
        end else begin
            // hold limit fits the counter in this branch
            state_next.lost_count = llrs_pkg::cnt_t'(cfg.hold_frames);
            result.grace_pending  = 1'b1;
            if (state_cur.stopped_for_good) begin
                result.action = llrs_pkg::ACT_STOP;
            end else if (!state_cur.in_pause) begin
                result.drive_confidence = item.confidence;
                if (llrs_pkg::ge_cnt_cfg(phase_inc, cfg.maneuver_frames)) begin
                    state_next.in_pause    = 1'b1;
                    state_next.phase_count = '0;
                    result.action          = llrs_pkg::ACT_MANEUVER_STOP;
                end else begin
                    state_next.phase_count = phase_inc;
                    result.action          = llrs_pkg::ACT_MANEUVER;
                end
            end else begin
                result.action          = llrs_pkg::ACT_STOP;
                state_next.phase_count = phase_inc;
                if (llrs_pkg::ge_cnt_cfg(phase_inc, cfg.pause_frames)) begin
                    state_next.cycle_count = cycle_inc;
                    if (llrs_pkg::ge_cnt_cfg(cycle_inc, cfg.max_cycles)) begin
                        state_next.stopped_for_good = 1'b1;
                    end else begin
                        state_next.in_pause    = 1'b0;
                        state_next.phase_count = '0;
                    end
                end
            end
        end
    end

endmodule

// ===== hdl/llrs_checker.sv =====
// llrs_checker: port-level assertions for the recovery sequencer, bound to the top level
module llrs_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic [2:0] m_action,
    input logic [1:0] m_coast_class,
    input logic [7:0] m_drive_confidence,
    input logic       m_grace_pending
);

    // no result straight after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // stalled result holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_action) && $stable(m_grace_pending)
            && $stable(m_drive_confidence) && $stable(m_coast_class))
        else $error("stalled result changed");

    // coasting means the hold limit is not reached
    a_coast_no_grace: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_action == llrs_pkg::ACT_COAST |-> !m_grace_pending)
        else $error("coast with grace pending");

    // maneuvers only after the hold limit
    a_maneuver_grace: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_action == llrs_pkg::ACT_MANEUVER
            || m_action == llrs_pkg::ACT_MANEUVER_STOP) |-> m_grace_pending && m_coast_class == 2'd0)
        else $error("maneuver without grace or with coast class");

    // no drive confidence outside maneuvers
    a_no_drive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_action == llrs_pkg::ACT_COAST || m_action == llrs_pkg::ACT_STOP
            || m_action == llrs_pkg::ACT_RESET_DONE) |-> m_drive_confidence == 8'd0)
        else $error("drive confidence outside maneuver");

endmodule

bind lost_line_recovery_sequencer_top llrs_checker u_llrs_checker (
    .aclk               (aclk),
    .aresetn            (aresetn),
    .m_valid            (m_valid),
    .m_ready            (m_ready),
    .m_action           (m_action),
    .m_coast_class      (m_coast_class),
    .m_drive_confidence (m_drive_confidence),
    .m_grace_pending    (m_grace_pending)
);
